// File: rtl/core/iraa_pkg.sv
// ----------------------------------------------------------------------------
// iraa_pkg: shared widths for the interval reservation admission block
// Field widths of the request and result beats and of the load values.
// ----------------------------------------------------------------------------
`default_nettype none
package iraa_pkg;
  localparam int SLOT_W = 11;
  localparam int LOAD_W = 16;
endpackage
`default_nettype wire

// File: rtl/core/iraa_if.sv
// ----------------------------------------------------------------------------
// iraa_if: request and result channels
// Valid/ready channels that carry one request or one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface iraa_req_if
  import iraa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] start_slot;
  logic [SLOT_W-1:0] end_slot;
  modport source (output valid, output start_slot, output end_slot, input ready);
  modport sink (input valid, input start_slot, input end_slot, output ready);
endinterface

interface iraa_res_if
  import iraa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [LOAD_W-1:0] peak_load;
  modport source (output valid, output accepted, output peak_load, input ready);
  modport sink (input valid, input accepted, input peak_load, output ready);
endinterface
`default_nettype wire

// File: rtl/core/iraa_ram.sv
// ----------------------------------------------------------------------------
// iraa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module iraa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/interval_reservation_admission.sv
// ----------------------------------------------------------------------------
// interval_reservation_admission: range reservation against a slot capacity
// Reads the peak load over a slot range and, when it is below capacity,
// adds one to every slot of the range. Loads live in one slot RAM.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                  Beat
// in_req    in   start_slot, end_slot     one request
// out_res   out  accepted, peak_load      one result per request
// cfg       in   cfg_wr_data (capacity)   written when cfg_wr_en is high
//
// S_QRY reads the covered slots and S_DEC registers the result once the
// output register is free; an empty range skips the scan. The single RAM read
// port scans one slot per cycle. An admitted request then keeps the input
// closed while the slots are written back. After reset a clearing pass over
// every slot runs before the first request is taken. A stalled result is
// held in the output register while the next request is taken and scanned.
`default_nettype none
module interval_reservation_admission
  import iraa_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [LOAD_W-1:0] cfg_wr_data,
  iraa_req_if.sink               in_req,
  iraa_res_if.source             out_res
);
  localparam int AW = $clog2(SLOTS);
  localparam int XW = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_QRY, S_QDRAIN, S_DEC, S_UPD, S_UDRAIN
  } state_t;

  state_t            state;
  logic [LOAD_W-1:0] capacity;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     lo_a;
  logic [AW-1:0]     hi_a;
  logic [AW-1:0]     prev_addr;
  logic              rd_pend;
  logic              empty;
  logic [LOAD_W-1:0] peak;
  logic              out_valid;
  logic              out_acc;
  logic [LOAD_W-1:0] out_peak;

  logic [XW-1:0]     s_x, e_x, lo_x, hi_x;
  logic              empty_next;
  logic              re, we;
  logic [AW-1:0]     waddr;
  logic [LOAD_W-1:0] wdata, rdata;
  logic              ok;

  always_comb begin
    s_x  = XW'(in_req.start_slot);
    e_x  = XW'(in_req.end_slot);
    lo_x = (s_x == '0) ? XW'(1) : s_x;
    hi_x = (e_x == '0) ? '0 : e_x - XW'(1);
    if (hi_x > XW'(SLOTS)) begin
      hi_x = XW'(SLOTS);
    end
    empty_next = (e_x == '0) || (lo_x > hi_x);
  end

  assign ok = peak < capacity;
  assign re = (state == S_QRY) || (state == S_UPD);

  always_comb begin
    we    = 1'b0;
    waddr = prev_addr;
    wdata = rdata + LOAD_W'(1);
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = ptr;
      wdata = '0;
    end else if ((state == S_UPD || state == S_UDRAIN) && rd_pend) begin
      we = 1'b1;
    end
  end

  iraa_ram #(.WIDTH(LOAD_W), .DEPTH(SLOTS)) u_load_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (ptr),
    .rdata (rdata)
  );

  assign in_req.ready      = (state == S_IDLE);
  assign out_res.valid     = out_valid;
  assign out_res.accepted  = out_acc;
  assign out_res.peak_load = out_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      capacity  <= LOAD_W'(1);
      ptr       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (out_valid && out_res.ready && state != S_DEC) begin
        out_valid <= 1'b0;
      end
      rd_pend <= re;
      if (re) begin
        prev_addr <= ptr;
      end
      if ((state == S_QRY || state == S_QDRAIN) && rd_pend && rdata > peak) begin
        peak <= rdata;
      end
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + AW'(1);
          if (ptr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_req.valid) begin
            lo_a  <= AW'(lo_x - XW'(1));
            hi_a  <= AW'(hi_x - XW'(1));
            ptr   <= AW'(lo_x - XW'(1));
            empty <= empty_next;
            peak  <= '0;
            state <= empty_next ? S_DEC : S_QRY;
          end
        end
        S_QRY: begin
          ptr <= ptr + AW'(1);
          if (ptr == hi_a) begin
            state <= S_QDRAIN;
          end
        end
        S_QDRAIN: begin
          state <= S_DEC;
        end
        S_DEC: begin
          if (!out_valid || out_res.ready) begin
            out_valid <= 1'b1;
            out_acc   <= ok;
            out_peak  <= peak;
            ptr       <= lo_a;
            state     <= (ok && !empty) ? S_UPD : S_IDLE;
          end
        end
        S_UPD: begin
          ptr <= ptr + AW'(1);
          if (ptr == hi_a) begin
            state <= S_UDRAIN;
          end
        end
        S_UDRAIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: test/iraa_checker.sv
// ----------------------------------------------------------------------------
// iraa_checker: admission predictor and result comparison
// Tracks the capacity register and every slot load from the request beats,
// predicts each result and compares it with the result beats in order.
// ----------------------------------------------------------------------------
`default_nettype none
module iraa_checker
  import iraa_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [LOAD_W-1:0] cfg_wr_data,
  iraa_req_if                    in_req,
  iraa_res_if                    out_res,
  output int                     pending,
  output int                     failures
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              accepted;
    logic [LOAD_W-1:0] peak_load;
  } verdict_t;

  logic [LOAD_W-1:0] slot_load [1:SLOTS];
  logic [LOAD_W-1:0] capacity;
  verdict_t          verdicts_due[$];

  function automatic verdict_t admit(input logic [SLOT_W-1:0] s, input logic [SLOT_W-1:0] e);
    int       lo;
    int       hi;
    verdict_t v;
    lo = (s == 0) ? 1 : int'(s);
    hi = (e == 0) ? 0 : int'(e) - 1;
    if (hi > SLOTS) hi = SLOTS;
    v.peak_load = '0;
    for (int i = lo; i <= hi; i++) begin
      if (slot_load[i] > v.peak_load) v.peak_load = slot_load[i];
    end
    v.accepted = v.peak_load < capacity;
    if (v.accepted) begin
      for (int i = lo; i <= hi; i++) slot_load[i] = slot_load[i] + 1'b1;
    end
    return v;
  endfunction

  assign pending = verdicts_due.size();

  always @(posedge clk) begin
    verdict_t want;
    int       errs;
    if (rst) begin
      capacity = 16'd1;
      for (int i = 1; i <= SLOTS; i++) slot_load[i] = '0;
      verdicts_due.delete();
      failures <= 0;
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_req.valid && in_req.ready) begin
        verdicts_due = {verdicts_due, admit(in_req.start_slot, in_req.end_slot)};
      end
      if (out_res.valid && out_res.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result beat with nothing expected");
          failures <= failures + 1;
        end else begin
          want = verdicts_due.pop_front();
          errs = 0;
          if (out_res.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_res.accepted);
            errs++;
          end
          if (out_res.peak_load !== want.peak_load) begin
            $error("peak_load: expected %0d, got %0d", want.peak_load, out_res.peak_load);
            errs++;
          end
          if (errs != 0) failures <= failures + errs;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for interval_reservation_admission
// Drives directed and random reservation requests under several capacity
// settings with random gaps on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top
  import iraa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 1024;
  localparam int DRAIN      = 2 * SLOTS + 64;
  localparam int LIMIT      = 10000000;
  localparam int RAND_ITEMS = 110;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [LOAD_W-1:0] cfg_wr_data = '0;
  int                pending;
  int                failures;
  int                cycles = 0;
  bit                calm = 1'b0;
  int                stall_left = 0;

  iraa_req_if in_req ();
  iraa_res_if out_res ();

  initial begin
    in_req.valid      = 1'b0;
    in_req.start_slot = '0;
    in_req.end_slot   = '0;
    out_res.ready     = 1'b0;
  end

  interval_reservation_admission #(.SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_req(in_req), .out_res(out_res)
  );

  iraa_checker #(.SLOTS(SLOTS)) u_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_req(in_req), .out_res(out_res), .pending(pending), .failures(failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_res.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_res.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap() - 1;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  task automatic send(input int s, input int e);
    in_req.valid      <= 1'b1;
    in_req.start_slot <= s[SLOT_W-1:0];
    in_req.end_slot   <= e[SLOT_W-1:0];
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_req.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [LOAD_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_requests(input int count);
    int s;
    int len;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85) begin
        s = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 48) : $urandom_range(1, SLOTS);
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(1, SLOTS) : $urandom_range(1, 16);
        send(s, s + len);
      end else begin
        send($urandom_range(0, 2047), $urandom_range(0, 2047));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    calm = 1'b1;
    send(0, 0);
    send(0, 3);
    send(1, 2);
    send(1, 2);
    send(2, 4);
    send(5, 5);
    send(9, 4);
    send(1024, 1025);
    send(1024, 2047);
    send(1025, 2047);
    send(2047, 2047);
    send(2047, 0);
    send(1, 1025);
    send(0, 2047);
    send(1000, 1030);
    calm = 1'b0;
    send(512, 513);
    send(300, 310);
    settle();

    set_capacity(16'd0);
    send(0, 0);
    send(1, 1025);
    send(7, 9);
    random_requests(15);
    settle();

    set_capacity(16'hFFFF);
    send(1, 1025);
    send(0, 2047);
    send(3, 3);
    random_requests(RAND_ITEMS);
    settle();

    set_capacity(16'd3);
    calm = 1'b1;
    random_requests(60);
    calm = 1'b0;
    random_requests(RAND_ITEMS);
    settle();

    set_capacity(16'd1);
    random_requests(RAND_ITEMS);
    settle();

    set_capacity(16'($urandom_range(2, 12)));
    random_requests(RAND_ITEMS);
    settle();

    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
